// File: sv/smr_pkg.sv
// Package with the shared sizes and constants of the structured Moran round unit.
`timescale 1ns / 1ps
package smr_pkg;
    localparam int MaxInd = 128;
    localparam int MaxPos = 64;
    localparam int IndW = 7;
    localparam int PosW = 6;
    localparam int DrawW = 16;
    localparam int SumW = 48;
    localparam logic [SumW-1:0] SumMax = '1;
    localparam logic [2:0] RegPop = 3'd0;
    localparam logic [2:0] RegPos = 3'd1;
    localparam logic [2:0] RegStep = 3'd2;
    localparam logic [2:0] RegMove = 3'd3;
    localparam logic [2:0] RegRedraw = 3'd4;
endpackage

// File: sv/structured_moran_round_unit.sv
// Top level of the structured Moran round unit: population memory and round sequencer.
`timescale 1ns / 1ps
// A load transaction reduces the loaded position modulo the position count in S_LOAD_MOD,
// writes it in S_LOAD_WR and returns its result from S_OUT. A round transaction clears
// all 64 entries of the position tally memory, walks the individual memory once to tally
// positions (read, two-part reduction, tally read, tally write-back for each), walks the
// position tally memory (read and accumulate for each site), and walks the individual
// memory a second time for the roulette wheel, stopping at the parent or the last one.
// Each memory has a single read port, and each position reduction is split into an
// upper-half and a lower-half step. After reset, a clearing pass zeroes all 128 entries
// of the individual memory before the first transaction is taken.
module structured_moran_round_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [6:0]  i_load_index,
    input  logic [5:0]  i_load_position,
    input  logic        i_load_strategy,
    input  logic [15:0] i_toss,
    input  logic [15:0] i_move_draw,
    input  logic [5:0]  i_step_magnitude,
    input  logic        i_step_negative,
    input  logic [15:0] i_redraw_draw,
    input  logic        i_redraw_strategy,
    input  logic [6:0]  i_victim_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_parent_index,
    output logic [5:0]  o_new_position,
    output logic        o_new_strategy,
    output logic [7:0]  o_coop_count,
    output logic [14:0] o_round_icc,
    output logic [12:0] o_round_icd,
    output logic [13:0] o_payoff_total,
    output logic [47:0] o_icc_weighted_sum,
    output logic [47:0] o_icd_weighted_sum,
    output logic [47:0] o_coop_count_sum,
    output logic [31:0] o_round_count
);
    localparam int IW = smr_pkg::IndW;
    localparam int PW = smr_pkg::PosW;
    localparam int SW = smr_pkg::SumW;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOAD_MOD, S_LOAD_WR,
        S_CLR_SITE, S_TALLY_RD, S_TALLY_MOD, S_TALLY_RED, S_TALLY_RMW, S_TALLY_WB,
        S_SITE_RD, S_SITE_ACC, S_ACC_MUL, S_ACC_ADD,
        S_WHEEL_RD, S_WHEEL_MOD, S_WHEEL_RED, S_WHEEL_SRD, S_WHEEL_CMP,
        S_PAR_RD, S_PAR_MOD, S_PAR_RED, S_STEP, S_WRAP, S_WRITE, S_OUT
    } t_state;

    t_state r_state;
    logic [7:0]  r_pop;
    logic [6:0]  r_npos;
    logic [5:0]  r_max_step;
    logic [15:0] r_prob_move;
    logic [15:0] r_prob_redraw;

    logic r_action, r_load_strategy, r_step_negative, r_redraw_strategy;
    logic [IW-1:0] r_load_index, r_victim;
    logic [15:0] r_toss, r_move_draw, r_redraw_draw;
    logic [5:0]  r_step_mag;

    logic [IW:0]   r_idx;
    logic [PW:0]   r_site;
    logic [PW-1:0] r_posmod;
    logic [7:0]  r_coop, r_defect;
    logic [14:0] r_icc;
    logic [12:0] r_icd;
    logic [13:0] r_total;
    logic [29:0] r_thresh;
    logic [13:0] r_cum;
    logic [IW-1:0] r_parent;
    logic [PW-1:0] r_newpos;
    logic r_newstrat;
    logic [6:0] r_tmp;
    logic [22:0] r_prod_icc;
    logic [20:0] r_prod_icd;
    logic [SW-1:0] r_acc_icc, r_acc_icd, r_acc_coop;
    logic [31:0] r_rounds;

    logic [IW-1:0] mem_waddr, mem_raddr;
    logic mem_we;
    logic [PW:0] mem_wdata, mem_rdata;
    logic [PW-1:0] site_waddr, site_raddr;
    logic site_we;
    logic [15:0] site_wdata, site_rdata;

    smr_ram #(.Width(PW + 1), .Depth(smr_pkg::MaxInd)) u_member (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );
    smr_ram #(.Width(16), .Depth(smr_pkg::MaxPos)) u_site (
        .i_clk(i_clk), .i_we(site_we), .i_waddr(site_waddr), .i_wdata(site_wdata),
        .i_raddr(site_raddr), .o_rdata(site_rdata)
    );

    // Three restoring remainder steps: the upper half (shifts 5 to 3) or the lower half.
    function automatic logic [6:0] mod_part(logic [6:0] v, logic [6:0] p, logic hi);
        logic [12:0] d;
        logic [6:0] x;
        x = v;
        for (int k = 2; k >= 0; k--) begin
            d = 13'(p) << (hi ? k + 3 : k);
            if (13'(x) >= d) begin
                x = x - d[6:0];
            end
        end
        return x;
    endfunction

    logic [7:0] pop_eff;
    logic [6:0] npos_eff;
    logic [PW-1:0] mem_pos;
    logic [6:0] pos_mod;
    logic [7:0] site_c, site_d, site_t;
    logic [5:0] step_cl;
    logic [6:0] wrap_sum;
    logic [13:0] cum_next;
    logic [29:0] cum_sh;

    always_comb begin
        pop_eff = (r_pop == 8'd0) ? 8'd1 : ((r_pop > 8'(smr_pkg::MaxInd)) ?
                  8'(smr_pkg::MaxInd) : r_pop);
        npos_eff = (r_npos == 7'd0) ? 7'd1 : ((r_npos > 7'(smr_pkg::MaxPos)) ?
                   7'(smr_pkg::MaxPos) : r_npos);
        mem_pos = mem_rdata[PW:1];
        site_c = site_rdata[15:8];
        site_d = site_rdata[7:0];
        site_t = site_c + site_d;
        pos_mod = (r_tmp >= npos_eff) ? r_tmp - npos_eff : r_tmp;
        step_cl = (r_step_mag > r_max_step) ? r_max_step : r_step_mag;
        if (7'(step_cl) > npos_eff - 7'd1) begin
            step_cl = 6'(npos_eff - 7'd1);
        end
        wrap_sum = r_step_negative ? 7'(r_newpos) + npos_eff - 7'(step_cl)
                                   : 7'(r_newpos) + 7'(step_cl);
        cum_next = r_cum + 14'(site_t) - 14'd1;
        cum_sh = {cum_next, 16'd0};
    end

    always_comb begin
        mem_we = 1'b0;
        mem_waddr = r_idx[IW-1:0];
        mem_wdata = '0;
        mem_raddr = r_idx[IW-1:0];
        site_we = 1'b0;
        site_waddr = r_posmod;
        site_wdata = '0;
        site_raddr = r_site[PW-1:0];
        unique case (r_state)
            S_CLEAR: mem_we = 1'b1;
            S_LOAD_WR: begin
                mem_we = 1'b1;
                mem_waddr = r_load_index;
                mem_wdata = {r_posmod, r_load_strategy};
            end
            S_CLR_SITE: begin
                site_we = 1'b1;
                site_waddr = r_site[PW-1:0];
            end
            S_TALLY_RMW, S_WHEEL_SRD: site_raddr = r_posmod;
            S_TALLY_WB: begin
                site_we = 1'b1;
                site_wdata = r_newstrat ? {site_c, site_d + 8'd1}
                                        : {site_c + 8'd1, site_d};
            end
            S_PAR_RD: mem_raddr = r_parent;
            S_WRITE: begin
                mem_we = 1'b1;
                mem_waddr = r_victim;
                mem_wdata = {r_newpos, r_newstrat};
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pop <= 8'd100;
            r_npos <= 7'd30;
            r_max_step <= 6'd1;
            r_prob_move <= 16'd32768;
            r_prob_redraw <= 16'd32768;
            r_acc_icc <= '0;
            r_acc_icd <= '0;
            r_acc_coop <= '0;
            r_rounds <= '0;
            r_idx <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    smr_pkg::RegPop: r_pop <= i_cfg_data[7:0];
                    smr_pkg::RegPos: r_npos <= i_cfg_data[6:0];
                    smr_pkg::RegStep: r_max_step <= i_cfg_data[5:0];
                    smr_pkg::RegMove: r_prob_move <= i_cfg_data;
                    smr_pkg::RegRedraw: r_prob_redraw <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == (IW + 1)'(smr_pkg::MaxInd - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: if (i_valid && o_ready) begin
                    r_action <= i_action;
                    r_load_index <= i_load_index;
                    r_load_strategy <= i_load_strategy;
                    r_toss <= i_toss;
                    r_move_draw <= i_move_draw;
                    r_step_mag <= i_step_magnitude;
                    r_step_negative <= i_step_negative;
                    r_redraw_draw <= i_redraw_draw;
                    r_redraw_strategy <= i_redraw_strategy;
                    r_victim <= (7'(i_victim_index) > 7'(pop_eff - 8'd1)) ?
                                IW'(pop_eff - 8'd1) : i_victim_index;
                    r_tmp <= 7'(i_load_position);
                    r_idx <= '0;
                    r_site <= '0;
                    r_coop <= '0;
                    r_defect <= '0;
                    r_icc <= '0;
                    r_icd <= '0;
                    r_total <= '0;
                    r_cum <= '0;
                    r_parent <= '0;
                    r_state <= i_action ? S_CLR_SITE : S_LOAD_MOD;
                end
                S_LOAD_MOD: begin
                    if (pos_mod >= npos_eff) begin
                        r_tmp <= pos_mod - npos_eff;
                    end else begin
                        r_posmod <= PW'(pos_mod);
                        r_state <= S_LOAD_WR;
                    end
                end
                S_LOAD_WR: begin
                    r_parent <= '0;
                    r_newpos <= '0;
                    r_newstrat <= 1'b0;
                    r_state <= S_OUT;
                end
                S_CLR_SITE: begin
                    r_site <= r_site + 1'b1;
                    if (r_site == (PW + 1)'(smr_pkg::MaxPos - 1)) begin
                        r_state <= S_TALLY_RD;
                    end
                end
                S_TALLY_RD: r_state <= S_TALLY_MOD;
                S_TALLY_MOD: begin
                    r_tmp <= mod_part(7'(mem_pos), npos_eff, 1'b1);
                    r_newstrat <= mem_rdata[0];
                    r_state <= S_TALLY_RED;
                end
                S_TALLY_RED: begin
                    r_posmod <= PW'(mod_part(r_tmp, npos_eff, 1'b0));
                    r_state <= S_TALLY_RMW;
                end
                S_TALLY_RMW: r_state <= S_TALLY_WB;
                S_TALLY_WB: begin
                    if (r_newstrat) begin
                        r_defect <= r_defect + 8'd1;
                    end else begin
                        r_coop <= r_coop + 8'd1;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (8'(r_idx) == pop_eff - 8'd1) begin
                        r_site <= '0;
                        r_state <= S_SITE_RD;
                    end else begin
                        r_state <= S_TALLY_RD;
                    end
                end
                S_SITE_RD: r_state <= S_SITE_ACC;
                S_SITE_ACC: begin
                    r_icc <= r_icc + 15'(site_c * site_c);
                    r_icd <= r_icd + 13'(site_c * site_d);
                    r_total <= r_total + ((site_t == 8'd0) ? 14'd0 :
                               14'(site_t * (site_t - 8'd1)));
                    r_site <= r_site + 1'b1;
                    r_state <= (7'(r_site) == npos_eff - 7'd1) ? S_ACC_MUL : S_SITE_RD;
                end
                S_ACC_MUL: begin
                    r_prod_icc <= r_icc * r_defect;
                    r_prod_icd <= r_icd * r_defect;
                    r_thresh <= r_toss * r_total;
                    r_state <= S_ACC_ADD;
                end
                S_ACC_ADD: begin
                    r_acc_icc <= (r_acc_icc > smr_pkg::SumMax - SW'(r_prod_icc)) ?
                                 smr_pkg::SumMax : r_acc_icc + SW'(r_prod_icc);
                    r_acc_icd <= (r_acc_icd > smr_pkg::SumMax - SW'(r_prod_icd)) ?
                                 smr_pkg::SumMax : r_acc_icd + SW'(r_prod_icd);
                    r_acc_coop <= (r_acc_coop > smr_pkg::SumMax - SW'(r_coop)) ?
                                  smr_pkg::SumMax : r_acc_coop + SW'(r_coop);
                    if (r_rounds != '1) begin
                        r_rounds <= r_rounds + 32'd1;
                    end
                    r_idx <= '0;
                    r_state <= (r_total == 14'd0) ? S_PAR_RD : S_WHEEL_RD;
                end
                S_WHEEL_RD: r_state <= S_WHEEL_MOD;
                S_WHEEL_MOD: begin
                    r_tmp <= mod_part(7'(mem_pos), npos_eff, 1'b1);
                    r_state <= S_WHEEL_RED;
                end
                S_WHEEL_RED: begin
                    r_posmod <= PW'(mod_part(r_tmp, npos_eff, 1'b0));
                    r_state <= S_WHEEL_SRD;
                end
                S_WHEEL_SRD: r_state <= S_WHEEL_CMP;
                S_WHEEL_CMP: begin
                    r_cum <= cum_next;
                    if (cum_sh >= r_thresh || 8'(r_idx) == pop_eff - 8'd1) begin
                        r_parent <= (cum_sh >= r_thresh) ? r_idx[IW-1:0] : '0;
                        r_state <= S_PAR_RD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_WHEEL_RD;
                    end
                end
                S_PAR_RD: r_state <= S_PAR_MOD;
                S_PAR_MOD: begin
                    r_tmp <= mod_part(7'(mem_pos), npos_eff, 1'b1);
                    r_newstrat <= (r_redraw_draw < r_prob_redraw) ?
                                  r_redraw_strategy : mem_rdata[0];
                    r_state <= S_PAR_RED;
                end
                S_PAR_RED: begin
                    r_newpos <= PW'(mod_part(r_tmp, npos_eff, 1'b0));
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_tmp <= wrap_sum;
                    r_state <= (r_move_draw < r_prob_move) ? S_WRAP : S_WRITE;
                end
                S_WRAP: begin
                    r_newpos <= PW'(pos_mod);
                    r_state <= S_WRITE;
                end
                S_WRITE: r_state <= S_OUT;
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            o_parent_index <= r_parent;
            o_new_position <= r_newpos;
            o_new_strategy <= r_newstrat;
            o_coop_count <= r_action ? r_coop : 8'd0;
            o_round_icc <= r_action ? r_icc : 15'd0;
            o_round_icd <= r_action ? r_icd : 13'd0;
            o_payoff_total <= r_action ? r_total : 14'd0;
            o_icc_weighted_sum <= r_acc_icc;
            o_icd_weighted_sum <= r_acc_icd;
            o_coop_count_sum <= r_acc_coop;
            o_round_count <= r_rounds;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_after_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT)) else $error("stray result");
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ACC_ADD) |=> $stable(r_rounds)) else $error("count moved");
endmodule

// File: sv/smr_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module smr_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
